>>> design/ncpe_pkg.sv
// shared constants, register codes and the per-sample square wave function
// for the composite pixel encoder; no dependencies
package ncpe_pkg;

    localparam int PIX_W      = 9;
    localparam int PHASE_W    = 4;
    localparam int SAMPLE_W   = 12;
    localparam int IRE_W      = 14;
    localparam int GAIN_W     = 9;
    localparam int PROD_W     = 15;
    localparam int LEVEL_W    = 8;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [PHASE_W-1:0] PHASES     = 4'd12;
    localparam logic [PHASE_W-1:0] PHASE_STEP = 4'd3;

    localparam logic [3:0] HUE_ALWAYS_HI = 4'h0;
    localparam logic [3:0] HUE_ALWAYS_LO = 4'hd;
    localparam logic [3:0] HUE_BLANK     = 4'he;

    localparam logic signed [SAMPLE_W-1:0] BRI_STEP    = 12'sd300;
    localparam logic signed [SAMPLE_W-1:0] HI_OFFSET   = 12'sd410;
    localparam logic signed [SAMPLE_W-1:0] LO_OFFSET   = 12'sd300;
    localparam logic signed [SAMPLE_W-1:0] LEVEL_CLAMP = 12'sd1024;

    // gain = floor(peak * contrast / 100) via reciprocal multiply
    localparam int                GAIN_DIV   = 100;
    localparam int                GAIN_SHIFT = 21;
    localparam logic [PROD_W-1:0] GAIN_RECIP = PROD_W'(((1 << GAIN_SHIFT) + GAIN_DIV - 1)
                                                      / GAIN_DIV);
    localparam int                OUT_SHIFT  = 12;

    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 8'sd127;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -8'sd128;

    localparam logic [7:0]        RST_OFFSET   = 8'd0;
    localparam logic [7:0]        RST_CONTRAST = 8'd100;
    localparam logic [6:0]        RST_PEDESTAL = 7'd0;
    localparam logic [6:0]        RST_PEAK     = 7'd100;
    localparam logic [GAIN_W-1:0] RST_GAIN     = 9'd100;
    localparam logic [PROD_W-1:0] RST_PROD     = 15'd10000;

    typedef enum logic [1:0] {
        REG_OFFSET   = 2'd0,
        REG_CONTRAST = 2'd1,
        REG_PEDESTAL = 2'd2,
        REG_PEAK     = 2'd3
    } t_reg_idx;

    // emphasis bits (pixel 8:6) that are active at a given half phase
    function automatic logic [2:0] emph_mask(input logic [2:0] idx);
        logic [2:0] m;
        case (idx)
            3'd0:    m = 3'b011;
            3'd1:    m = 3'b001;
            3'd2:    m = 3'b101;
            3'd3:    m = 3'b100;
            3'd4:    m = 3'b110;
            3'd5:    m = 3'b010;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    // one square wave sample at phase ph (0..14, not wrapped)
    function automatic logic signed [SAMPLE_W-1:0] wave_sample(
        input logic [PIX_W-1:0]   pix,
        input logic [PHASE_W-1:0] ph
    );
        logic [3:0]                 hue;
        logic [4:0]                 hp;
        logic [3:0]                 hm;
        logic [2:0]                 ei;
        logic                       high;
        logic signed [SAMPLE_W-1:0] bx;
        logic signed [SAMPLE_W-1:0] v;
        logic signed [SAMPLE_W-1:0] r;
        hue = pix[3:0];
        hp  = {1'b0, hue} + {1'b0, ph};
        if (hp >= 5'd24) begin
            hm = 4'(hp - 5'd24);
        end else if (hp >= 5'd12) begin
            hm = 4'(hp - 5'd12);
        end else begin
            hm = hp[3:0];
        end
        if (hue == HUE_ALWAYS_HI) begin
            high = 1'b1;
        end else if (hue == HUE_ALWAYS_LO) begin
            high = 1'b0;
        end else begin
            high = (hm < 4'd6);
        end
        bx = $signed({10'd0, pix[5:4]}) * BRI_STEP;
        v  = high ? (bx + HI_OFFSET) : (bx - LO_OFFSET);
        if (v > LEVEL_CLAMP) begin
            v = LEVEL_CLAMP;
        end
        ei = ph[3:1];
        if (ei >= 3'd6) begin
            ei = ei - 3'd6;
        end
        if ((pix[8:6] & emph_mask(ei)) != 3'b000) begin
            r = (v >>> 1) + (v >>> 2);
        end else begin
            r = v;
        end
        if (hue >= HUE_BLANK) begin
            r = '0;
        end
        return r;
    endfunction

endpackage

>>> design/ncpe_wave_sum.sv
// sum of the four square wave samples of one pixel at phase+0..3
// depends on ncpe_pkg
module ncpe_wave_sum
    import ncpe_pkg::*;
(
    input  logic [PIX_W-1:0]          i_pixel,
    input  logic [PHASE_W-1:0]        i_phase,
    output logic signed [IRE_W-1:0]   o_sum
);

    logic signed [SAMPLE_W-1:0] smp [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            smp[k] = wave_sample(i_pixel, i_phase + PHASE_W'(k));
        end
    end

    assign o_sum = IRE_W'(smp[0]) + IRE_W'(smp[1]) + IRE_W'(smp[2]) + IRE_W'(smp[3]);

endmodule

>>> design/nes_composite_pixel_encoder.sv
// composite level encoder for nes palette pixels: top level with config regs
// one level word per cycle while neither i_stall nor o_stall holds the pipe;
// registers in order: input reg, sample sum reg, gain multiply into the output reg
// o_stall also rises after a config write and holds while the gain recomputes
// synchronous active-low reset: chroma phase 0, registers to defaults, pipe empty
// depends on ncpe_pkg and ncpe_wave_sum
module nes_composite_pixel_encoder
    import ncpe_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [PIX_W-1:0]           i_pixel,
    input  logic                       i_line_start,
    input  logic [PHASE_W-1:0]         i_line_phase,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [LEVEL_W-1:0]  o_level,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    // config registers and derived gain
    logic signed [7:0]   r_offset;
    logic [7:0]          r_contrast;
    logic [6:0]          r_pedestal;
    logic [6:0]          r_peak;
    logic [PROD_W-1:0]   r_prod;
    logic [GAIN_W-1:0]   r_gain;
    logic [1:0]          r_hold;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;
    logic [2*PROD_W-1:0] gain_full;

    // pipeline
    logic                      r_in_vld;
    logic [PIX_W-1:0]          r_pix;
    logic [PHASE_W-1:0]        r_phase_cur;
    logic [PHASE_W-1:0]        r_phase;
    logic                      r_ire_vld;
    logic signed [IRE_W-1:0]   r_ire;
    logic                      r_out_vld;
    logic signed [LEVEL_W-1:0] r_level;

    logic                      out_free;
    logic                      s2_free;
    logic                      in_free;
    logic                      accept;
    logic [PHASE_W-1:0]        load_phase;
    logic [PHASE_W-1:0]        cur_phase;
    logic [PHASE_W-1:0]        step_phase;
    logic [PHASE_W-1:0]        n_phase;
    logic signed [IRE_W-1:0]   wave_sum;
    logic signed [IRE_W-1:0]   n_ire;
    logic signed [IRE_W+GAIN_W:0] prod;
    logic signed [IRE_W+GAIN_W-OUT_SHIFT:0] scaled;
    logic signed [LEVEL_W-1:0] n_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= RST_OFFSET;
            r_contrast <= RST_CONTRAST;
            r_pedestal <= RST_PEDESTAL;
            r_peak     <= RST_PEAK;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OFFSET:   r_offset   <= $signed(pwdata[7:0]);
                REG_CONTRAST: r_contrast <= pwdata[7:0];
                REG_PEDESTAL: r_pedestal <= pwdata[6:0];
                REG_PEAK:     r_peak     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_OFFSET:   prdata = DATA_W'(r_offset);
            REG_CONTRAST: prdata = DATA_W'(r_contrast);
            REG_PEDESTAL: prdata = DATA_W'(r_pedestal);
            REG_PEAK:     prdata = DATA_W'(r_peak);
            default:      prdata = '0;
        endcase
    end

    // gain in two registered steps: product, then divide by 100 via reciprocal
    assign gain_full = r_prod * GAIN_RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= RST_PROD;
            r_gain <= RST_GAIN;
            r_hold <= 2'd0;
        end else begin
            r_prod <= PROD_W'(r_peak * r_contrast);
            r_gain <= gain_full[GAIN_SHIFT +: GAIN_W];
            if (cfg_wr) begin
                r_hold <= 2'd2;
            end else if (r_hold != 2'd0) begin
                r_hold <= r_hold - 2'd1;
            end
        end
    end

    // handshake chain
    assign out_free = !r_out_vld || !i_stall;
    assign s2_free  = !r_ire_vld || out_free;
    assign in_free  = !r_in_vld || s2_free;
    assign o_stall  = !in_free || (r_hold != 2'd0);
    assign accept   = i_valid && !o_stall;

    // chroma phase bookkeeping at acceptance
    always_comb begin
        load_phase = (i_line_phase >= PHASES) ? i_line_phase - PHASES : i_line_phase;
        cur_phase  = i_line_start ? load_phase : r_phase;
        step_phase = cur_phase + PHASE_STEP;
        n_phase    = (step_phase >= PHASES) ? step_phase - PHASES : step_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_in_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
            end
            if (in_free) begin
                r_in_vld <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix       <= i_pixel;
            r_phase_cur <= cur_phase;
        end
    end

    ncpe_wave_sum u_wave_sum (
        .i_pixel (r_pix),
        .i_phase (r_phase_cur),
        .o_sum   (wave_sum)
    );

    assign n_ire = wave_sum + $signed({{(IRE_W-7){1'b0}}, r_pedestal})
                 + IRE_W'(r_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ire_vld <= 1'b0;
        end else if (s2_free) begin
            r_ire_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_in_vld) begin
            r_ire <= n_ire;
        end
    end

    // scale, floor shift, saturate
    always_comb begin
        prod   = r_ire * $signed({1'b0, r_gain});
        scaled = prod[IRE_W+GAIN_W:OUT_SHIFT];
        if (scaled > (IRE_W+GAIN_W-OUT_SHIFT+1)'(LEVEL_MAX)) begin
            n_level = LEVEL_MAX;
        end else if (scaled < (IRE_W+GAIN_W-OUT_SHIFT+1)'(LEVEL_MIN)) begin
            n_level = LEVEL_MIN;
        end else begin
            n_level = scaled[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_ire_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_ire_vld) begin
            r_level <= n_level;
        end
    end

    assign o_valid = r_out_vld;
    assign o_level = r_level;

endmodule

>>> verif/nes_composite_pixel_encoder_test.sv
// self-checking testbench for nes_composite_pixel_encoder: pixels in, composite levels out
// a local predictor of the chroma phase and level math checks every level word in order
// depends on ncpe_pkg for port widths and register codes
module nes_composite_pixel_encoder_test;
    import ncpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;

    localparam logic [PIX_W-1:0] EMPH_FIELD = 9'o700;
    localparam logic [PIX_W-1:0] EMPH_MASKS [6] = '{9'o300, 9'o100, 9'o500,
                                                    9'o400, 9'o600, 9'o200};

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [PIX_W-1:0]           i_pixel;
    logic                       i_line_start;
    logic [PHASE_W-1:0]         i_line_phase;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [LEVEL_W-1:0]  o_level;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    nes_composite_pixel_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .i_line_start (i_line_start),
        .i_line_phase (i_line_phase),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_level      (o_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // predictor state
    int                         chroma_ph;
    logic signed [7:0]          offset_val;
    logic [7:0]                 contrast_val;
    logic [6:0]                 pedestal_val;
    logic [6:0]                 peak_val;

    logic signed [LEVEL_W-1:0]  expected_levels [$];
    int                         mismatches;
    int                         pixels_sent;
    int                         levels_checked;
    int                         settings_used;
    int                         cycle_count;
    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         hold_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic int wave_value(input logic [PIX_W-1:0] pix, input int ph);
        logic [3:0] hue;
        int         bri;
        int         v;
        bit         high;
        hue = pix[3:0];
        if (hue >= HUE_BLANK) begin
            return 0;
        end
        bri = int'(pix[5:4]) * 300;
        if (hue == HUE_ALWAYS_HI) begin
            high = 1'b1;
        end else if (hue == HUE_ALWAYS_LO) begin
            high = 1'b0;
        end else begin
            high = ((int'(hue) + ph) % 12) < 6;
        end
        v = high ? bri + 410 : bri - 300;
        if (v > 1024) begin
            v = 1024;
        end
        // attenuate to 3/4 when an emphasis bit is active at this half phase
        if ((pix & EMPH_FIELD & EMPH_MASKS[(ph >> 1) % 6]) != '0) begin
            v = (v >>> 1) + (v >>> 2);
        end
        return v;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] predict_level(
        input logic [PIX_W-1:0]   pix,
        input logic               ls,
        input logic [PHASE_W-1:0] lp
    );
        int ire;
        int gain;
        if (ls) begin
            chroma_ph = int'(lp) % 12;
        end
        ire = int'(pedestal_val) + int'(offset_val);
        for (int k = 0; k < 4; k++) begin
            ire += wave_value(pix, chroma_ph + k);
        end
        gain = (int'(peak_val) * int'(contrast_val)) / 100;
        ire  = (ire * gain) >>> 12;
        if (ire > 127) begin
            ire = 127;
        end
        if (ire < -128) begin
            ire = -128;
        end
        chroma_ph = (chroma_ph + 3) % 12;
        return LEVEL_W'(ire);
    endfunction

    // receiver: long hold-off when requested, else random stall
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall = 1'b1;
            hold_cycles--;
        end else begin
            i_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("unexpected level word %0d", o_level));
            end else begin
                logic signed [LEVEL_W-1:0] want;
                want = expected_levels.pop_front();
                levels_checked++;
                if (o_level !== want) begin
                    report_mismatch($sformatf("level %0d, expected %0d", o_level, want));
                end
            end
        end
    end

    task automatic send_pixel(
        input logic [PIX_W-1:0]   pix,
        input logic               ls,
        input logic [PHASE_W-1:0] lp
    );
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid      = 1'b1;
        i_pixel      = pix;
        i_line_start = ls;
        i_line_phase = lp;
        do @(posedge i_clk); while (o_stall);
        expected_levels.push_back(predict_level(pix, ls, lp));
        pixels_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_register(input t_reg_idx idx, input logic [7:0] val);
        wait_drained();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        // upper bits are noise the register must ignore
        pwdata  = ($urandom() & 32'hffff_ff00) | {24'd0, val};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_OFFSET:   offset_val   = val;
            REG_CONTRAST: contrast_val = val;
            REG_PEDESTAL: pedestal_val = val[6:0];
            REG_PEAK:     peak_val     = val[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        settings_used++;
    endtask

    task automatic set_all_registers(input logic [7:0] bp, input logic [7:0] wp,
                                     input logic [7:0] bl, input logic [7:0] wl);
        set_register(REG_OFFSET, bp);
        set_register(REG_CONTRAST, wp);
        set_register(REG_PEDESTAL, bl);
        set_register(REG_PEAK, wl);
    endtask

    function automatic logic [7:0] pick_value(input logic [7:0] lo, input logic [7:0] hi);
        int r;
        r = $urandom_range(7);
        if (r == 0) begin
            return lo;
        end else if (r == 1) begin
            return hi;
        end
        return 8'($urandom_range(int'(hi), int'(lo)));
    endfunction

    // defaults after reset: hue classes, clamp, emphasis, line phase loads
    task automatic test_default_pixels();
        send_pixel(9'h000, 1'b1, 4'd0);
        send_pixel(9'h00d, 1'b0, 4'd0);
        send_pixel(9'h00e, 1'b0, 4'd0);
        send_pixel(9'h00f, 1'b0, 4'd0);
        send_pixel(9'h030, 1'b0, 4'd0);
        send_pixel(9'h03d, 1'b0, 4'd0);
        send_pixel(9'h1ff, 1'b0, 4'd0);
        send_pixel(9'h1c0, 1'b0, 4'd0);
        send_pixel(9'h1f0, 1'b0, 4'd0);
        send_pixel(9'h005, 1'b1, 4'd11);
        send_pixel(9'h005, 1'b1, 4'd12);
        send_pixel(9'h007, 1'b1, 4'd15);
        send_pixel(9'h011, 1'b0, 4'd0);
        send_pixel(9'h026, 1'b0, 4'd0);
        send_pixel(9'h03c, 1'b0, 4'd0);
        send_pixel(9'h048, 1'b0, 4'd0);
        send_pixel(9'h09a, 1'b0, 4'd0);
        send_pixel(9'h10b, 1'b0, 4'd0);
    endtask

    // register extremes: saturation high, zero gain, largest negative offset
    task automatic test_register_extremes();
        set_all_registers(8'sd127, 8'd255, 8'd127, 8'd127);
        send_pixel(9'h030, 1'b1, 4'd3);
        send_pixel(9'h03f, 1'b0, 4'd0);
        set_all_registers(-8'sd128, 8'd0, 8'd0, 8'd0);
        send_pixel(9'h031, 1'b0, 4'd0);
        send_pixel(9'h00d, 1'b0, 4'd0);
        set_all_registers(-8'sd128, 8'd255, 8'd0, 8'd127);
        send_pixel(9'h00d, 1'b1, 4'd0);
        send_pixel(9'h1c2, 1'b0, 4'd0);
    endtask

    // offset flips the sign bit so the ends land on -128 and 127
    task automatic random_registers();
        set_all_registers(pick_value(8'd0, 8'd255) ^ 8'h80, pick_value(8'd0, 8'd255),
                          pick_value(8'd0, 8'd127), pick_value(8'd0, 8'd127));
    endtask

    // scan lines: a line start with a random phase, then pixels; some noise
    task automatic test_random_lines(input int count, input int s_pct, input int r_pct);
        int left;
        int run;
        logic [PHASE_W-1:0] lp;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        left = count;
        while (left > 0) begin
            if (left == count || $urandom_range(2) == 0) begin
                random_registers();
            end
            run = $urandom_range(40, 1);
            lp  = ($urandom_range(7) == 0) ? PHASE_W'($urandom_range(15, 12))
                                           : PHASE_W'($urandom_range(11));
            send_pixel(PIX_W'($urandom_range(511)), 1'b1, lp);
            left--;
            for (int n = 1; n < run && left > 0; n++) begin
                if ($urandom_range(19) == 0) begin
                    send_pixel(PIX_W'($urandom_range(511)), 1'b1,
                               PHASE_W'($urandom_range(15)));
                end else begin
                    send_pixel(PIX_W'($urandom_range(511)), 1'b0,
                               PHASE_W'($urandom_range(15)));
                end
                left--;
            end
        end
    endtask

    // receiver holds off long while the sender keeps offering words
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge i_clk);
        i_valid     = 1'b0;
        hold_cycles = 80;
        for (int n = 0; n < 30; n++) begin
            send_pixel(PIX_W'($urandom_range(511)), (n == 0), PHASE_W'($urandom_range(11)));
        end
    endtask

    // sender pauses until every level has come back, then resumes mid line
    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        for (int n = 0; n < 8; n++) begin
            send_pixel(PIX_W'($urandom_range(511)), 1'b0, 4'd0);
        end
        wait_drained();
        for (int n = 0; n < 8; n++) begin
            send_pixel(PIX_W'($urandom_range(511)), 1'b0, 4'd0);
        end
    endtask

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pixel       = '0;
        i_line_start  = 1'b0;
        i_line_phase  = '0;
        i_stall       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        chroma_ph     = 0;
        offset_val    = RST_OFFSET;
        contrast_val  = RST_CONTRAST;
        pedestal_val  = RST_PEDESTAL;
        peak_val      = RST_PEAK;
        mismatches    = 0;
        pixels_sent   = 0;
        levels_checked = 0;
        settings_used = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_pixels();
        test_register_extremes();
        test_random_lines(180, 20, 59);
        test_random_lines(180, 59, 20);
        test_random_lines(160, 0, 0);
        test_backpressure();
        test_drain_pause();

        @(negedge i_clk);
        i_valid       = 1'b0;
        recv_idle_pct = 0;
        waited = 0;
        while (expected_levels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_levels.size() != 0) begin
            report_mismatch($sformatf("%0d level words never arrived",
                                      expected_levels.size()));
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d pixels and %0d level words across %0d register writes,",
                 pixels_sent, levels_checked, settings_used);
        $display("with line phase loads, emphasis, blank hues, saturation and stalls");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
